### rtl/core/sem_pkg.sv
`timescale 1ns / 1ps

package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = COL_W + 1;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int HGT_W  = ROW_W + 1;
  localparam int TAIL_W = $clog2(MAX_WIDTH + 2);

  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int CFG_W  = 13;
  localparam int IDX_W  = 2;

  localparam int LINE_W = 2 * PIX_W;
  localparam int ACC_W  = PIX_W + 2;
  localparam int SQ_W   = 2 * ACC_W;
  localparam int RAD_W  = SQ_W + 1;
  localparam int ROOT_W = PIX_W;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic [0:0] CMD_PIXEL = 1'b0;
  localparam logic [0:0] CMD_FLUSH = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [COL_W-1:0]  addr;
    logic [LINE_W-1:0] wdata;
  } sem_ram_req_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sem_root_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sem_root_rsp_t;

endpackage

### rtl/core/sobel_edge_magnitude.sv
`timescale 1ns / 1ps
// channel | direction | words                   | handshake
// s_axis  | in        | pixel, command in tuser | s_axis_tvalid / s_axis_tready
// m_axis  | out       | edge value, frame end   | m_axis_tvalid / m_axis_tready
// cfg     | in        | register index, data    | cfg_valid / cfg_ready (always ready)
// one word at a time: a flush owing nothing stays idle, else outputs; a
// pixel passes update, then idle if no result, output if owed or border,
// else gradient, square, start and eight-step root (skipped on overflow);
// the line-store column is read on acceptance, written back in update;
// synchronous reset clears position, tail count, window and output valid;
// a new result waits in S_OUT while the last waits on m_axis_tready

module sobel_edge_magnitude (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] pixel
  input  logic                         s_axis_tuser,  // [0] command
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] edge_value
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sem_pkg::IDX_W-1:0]    cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]    cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_GRAD  = 3'd2;
  localparam logic [2:0] S_SQ    = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_ROOT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam int PW = sem_pkg::PIX_W;
  localparam int CW = sem_pkg::COL_W;
  localparam int RW = sem_pkg::ROW_W;
  localparam int AW = sem_pkg::ACC_W;

  logic [2:0] state;

  logic [sem_pkg::FW_W-1:0]   frame_width;
  logic [sem_pkg::FH_W-1:0]   frame_height;
  logic [sem_pkg::WID_W-1:0]  w;
  logic [sem_pkg::HGT_W-1:0]  h;
  logic [CW-1:0]              wlast;
  logic [RW-1:0]              hlast;

  logic [CW-1:0]              col;
  logic [RW-1:0]              row;
  logic [sem_pkg::TAIL_W-1:0] tail;
  logic [CW-1:0]              c_now;
  logic [RW-1:0]              r_now;
  logic [CW-1:0]              c_q;
  logic [RW-1:0]              r_q;
  logic [PW-1:0]              pix;

  logic [PW-1:0]              win [3][3];

  logic [RW-1:0]              cr;
  logic [CW-1:0]              cc;
  logic                       produce;
  logic                       border;
  logic                       end_flag;
  logic [sem_pkg::TAIL_W-1:0] tail_dec;

  logic [AW-1:0]              left, right, top, bottom;
  logic [AW-1:0]              ax, ay;
  logic [sem_pkg::SQ_W-1:0]   sqx, sqy;

  logic [PW-1:0]              res_value;
  logic                       res_last;
  logic                       out_valid;
  logic [PW-1:0]              out_value;
  logic                       out_last;

  sem_pkg::sem_ram_req_t      ram_req;
  logic [sem_pkg::LINE_W-1:0] ram_rdata;
  sem_pkg::sem_root_req_t     root_req;
  sem_pkg::sem_root_rsp_t     root_rsp;

  sem_line_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  sem_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

  // clamped frame geometry
  always_comb begin
    if (frame_width < sem_pkg::FW_W'(3)) begin
      w = sem_pkg::WID_W'(3);
    end else if (sem_pkg::WID_W'(frame_width) > sem_pkg::WID_W'(sem_pkg::MAX_WIDTH)) begin
      w = sem_pkg::WID_W'(sem_pkg::MAX_WIDTH);
    end else begin
      w = sem_pkg::WID_W'(frame_width);
    end
    if (frame_height < sem_pkg::FH_W'(3)) begin
      h = sem_pkg::HGT_W'(3);
    end else if (sem_pkg::HGT_W'(frame_height) > sem_pkg::HGT_W'(sem_pkg::MAX_HEIGHT)) begin
      h = sem_pkg::HGT_W'(sem_pkg::MAX_HEIGHT);
    end else begin
      h = sem_pkg::HGT_W'(frame_height);
    end
  end

  assign wlast = CW'(w - sem_pkg::WID_W'(1));
  assign hlast = RW'(h - sem_pkg::HGT_W'(1));
  assign c_now = (col > wlast) ? wlast : col;
  assign r_now = (row > hlast) ? hlast : row;

  // centre of the finished window
  always_comb begin
    produce  = (r_q >= RW'(2)) || (r_q == RW'(1) && c_q >= CW'(1));
    if (c_q == '0) begin
      cr = r_q - RW'(2);
      cc = wlast;
    end else begin
      cr = r_q - RW'(1);
      cc = c_q - CW'(1);
    end
    border   = (cr == '0) || (cr >= hlast) || (cc == '0) || (cc >= wlast);
    end_flag = (cr == hlast) && (cc == wlast);
    tail_dec = (tail != '0) ? tail - sem_pkg::TAIL_W'(1) : tail;
  end

  always_comb begin
    left   = AW'(win[0][0]) + {win[1][0], 1'b0} + AW'(win[2][0]);
    right  = AW'(win[0][2]) + {win[1][2], 1'b0} + AW'(win[2][2]);
    top    = AW'(win[0][0]) + {win[0][1], 1'b0} + AW'(win[0][2]);
    bottom = AW'(win[2][0]) + {win[2][1], 1'b0} + AW'(win[2][2]);
  end

  always_comb begin
    ram_req = '0;
    if (state == S_IDLE && s_axis_tvalid && s_axis_tuser == sem_pkg::CMD_PIXEL) begin
      ram_req.en   = 1'b1;
      ram_req.addr = c_now;
    end else if (state == S_UPD) begin
      ram_req.en    = 1'b1;
      ram_req.we    = 1'b1;
      ram_req.addr  = c_q;
      ram_req.wdata = {pix, ram_rdata[sem_pkg::LINE_W-1:PW]};
    end
  end

  assign root_req.start    = (state == S_START);
  assign root_req.radicand = sem_pkg::RAD_W'(sqx) + sem_pkg::RAD_W'(sqy);

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sem_pkg::FRAME_WIDTH_RST;
      frame_height <= sem_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sem_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[sem_pkg::FW_W-1:0];
        sem_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[sem_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col       <= '0;
      row       <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else begin
      if (out_valid && m_axis_tready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser == sem_pkg::CMD_FLUSH) begin
              if (tail != '0) begin
                res_value <= sem_pkg::PIX_MAX;
                res_last  <= (tail == sem_pkg::TAIL_W'(1));
                tail      <= tail_dec;
                state     <= S_OUT;
              end
            end else begin
              pix   <= s_axis_tdata;
              c_q   <= c_now;
              r_q   <= r_now;
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          for (int i = 0; i < 3; i++) begin
            win[i][0] <= win[i][1];
            win[i][1] <= win[i][2];
          end
          win[0][2] <= ram_rdata[PW-1:0];
          win[1][2] <= ram_rdata[sem_pkg::LINE_W-1:PW];
          win[2][2] <= pix;

          if (c_q == wlast) begin
            col <= '0;
            if (r_q == hlast) begin
              row  <= '0;
              tail <= sem_pkg::TAIL_W'(w) + sem_pkg::TAIL_W'(1);
            end else begin
              row  <= r_q + RW'(1);
              tail <= tail_dec;
            end
          end else begin
            col  <= c_q + CW'(1);
            row  <= r_q;
            tail <= tail_dec;
          end

          if (tail != '0) begin
            res_value <= sem_pkg::PIX_MAX;
            res_last  <= (tail == sem_pkg::TAIL_W'(1));
            state     <= S_OUT;
          end else if (produce) begin
            res_last <= end_flag;
            if (border) begin
              res_value <= sem_pkg::PIX_MAX;
              state     <= S_OUT;
            end else begin
              state <= S_GRAD;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_GRAD: begin
          ax    <= (left >= right) ? left - right : right - left;
          ay    <= (top >= bottom) ? top - bottom : bottom - top;
          state <= S_SQ;
        end
        S_SQ: begin
          sqx   <= sem_pkg::SQ_W'(ax) * sem_pkg::SQ_W'(ax);
          sqy   <= sem_pkg::SQ_W'(ay) * sem_pkg::SQ_W'(ay);
          state <= S_START;
        end
        S_START: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (root_rsp.done) begin
            res_value <= sem_pkg::PIX_MAX - root_rsp.root;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_value <= res_value;
            out_last  <= res_last;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tlast  = out_last;

  a_root_in_wait: assert property (@(posedge clk) disable iff (rst)
    root_rsp.done |-> state == S_ROOT)
    else $error("square root finished outside its wait state");

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= sem_pkg::TAIL_W'(sem_pkg::MAX_WIDTH + 1))
    else $error("tail count beyond a full row plus one");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !m_axis_tready) |=> state == S_OUT)
    else $error("result left the output state while the output word was stalled");

  a_ram_write_upd: assert property (@(posedge clk) disable iff (rst)
    (ram_req.en && ram_req.we) |-> $past(state == S_IDLE && s_axis_tvalid && s_axis_tready))
    else $error("line store write without a preceding read");

endmodule

### rtl/core/sem_line_ram.sv
`timescale 1ns / 1ps

module sem_line_ram (
  input  logic                                clk,
  input  sem_pkg::sem_ram_req_t               req,
  output logic [sem_pkg::LINE_W-1:0]          rdata
);

  // two line stores side by side, upper byte is the newer row
  logic [sem_pkg::LINE_W-1:0] mem [sem_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

### rtl/core/sem_isqrt.sv
`timescale 1ns / 1ps

module sem_isqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  sem_pkg::sem_root_req_t req,
  output sem_pkg::sem_root_rsp_t rsp
);

  localparam int HALF_W = 2 * sem_pkg::ROOT_W;

  logic [HALF_W-1:0]          rad;
  logic [sem_pkg::ROOT_W-1:0] root;
  logic [sem_pkg::ROOT_W-1:0] probe;
  logic                       done;
  logic [sem_pkg::ROOT_W-1:0] trial;
  logic [HALF_W-1:0]          trial_sq;

  assign trial    = root | probe;
  assign trial_sq = HALF_W'(trial) * HALF_W'(trial);

  // one result bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      probe <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (|req.radicand[sem_pkg::RAD_W-1:HALF_W]) begin
          root  <= '1;
          probe <= '0;
          done  <= 1'b1;
        end else begin
          rad   <= req.radicand[HALF_W-1:0];
          root  <= '0;
          probe <= {1'b1, {(sem_pkg::ROOT_W-1){1'b0}}};
        end
      end else if (|probe) begin
        if (trial_sq <= rad) begin
          root <= trial;
        end
        probe <= probe >> 1;
        if (probe[0]) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule
